// ----- design/xa_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package xa_pkg;

    localparam int unsigned SAMPLES_PER_UNIT = 28;
    localparam int unsigned CODE_BITS        = 8;
    localparam int unsigned CODES_W          = 56;
    localparam int unsigned UNIT_CODES_W     = 4 * CODES_W;
    localparam int unsigned IDX_W            = 5;

    localparam logic [3:0] RANGE_MAX   = 4'd12;
    localparam logic [3:0] RANGE_SUBST = 4'd9;
    localparam logic signed [4:0] BASE_4BIT = 5'sd12;
    localparam logic signed [4:0] BASE_8BIT = 5'sd8;

    localparam logic [1:0] FILT_NONE = 2'd0;
    localparam logic [1:0] FILT_ONE  = 2'd1;
    localparam logic [1:0] FILT_TWO  = 2'd2;
    localparam logic [1:0] FILT_THREE = 2'd3;

    typedef struct packed {
        logic [UNIT_CODES_W-1:0] codes;
        logic signed [4:0]       shift;
        logic [1:0]              filt;
        logic                    chan;
        logic                    eight_bit;
    } t_unit;

    function automatic logic signed [7:0] pos_coef(input logic [1:0] filt);
        logic signed [7:0] c;
        unique case (filt)
            FILT_NONE:  c = 8'sd0;
            FILT_ONE:   c = 8'sd60;
            FILT_TWO:   c = 8'sd115;
            FILT_THREE: c = 8'sd98;
            default:    c = 8'sd0;
        endcase
        return c;
    endfunction

    function automatic logic signed [7:0] neg_coef(input logic [1:0] filt);
        logic signed [7:0] c;
        unique case (filt)
            FILT_NONE:  c = 8'sd0;
            FILT_ONE:   c = 8'sd0;
            FILT_TWO:   c = -8'sd52;
            FILT_THREE: c = -8'sd55;
            default:    c = 8'sd0;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- design/xa_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module xa_front (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic [7:0]           i_unit_header,
    input  wire logic [xa_pkg::CODES_W-1:0] i_codes_a,
    input  wire logic [xa_pkg::CODES_W-1:0] i_codes_b,
    input  wire logic [xa_pkg::CODES_W-1:0] i_codes_c,
    input  wire logic [xa_pkg::CODES_W-1:0] i_codes_d,
    input  wire logic                 i_channel_sel,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic                 i_cfg_eight_bit_mode,
    output logic                      o_q_valid,
    input  wire logic                 i_q_ready,
    output xa_pkg::t_unit             o_q_data
);

    logic          r_mode;
    logic          r_valid;
    xa_pkg::t_unit r_unit;
    xa_pkg::t_unit n_unit;
    logic [3:0]    w_range;
    logic signed [4:0] w_base;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = !r_valid || i_q_ready;
    assign o_q_valid   = r_valid;
    assign o_q_data    = r_unit;

    // range 13..15 behaves as 9
    always_comb begin
        w_range = (i_unit_header[3:0] > xa_pkg::RANGE_MAX) ? xa_pkg::RANGE_SUBST
                                                           : i_unit_header[3:0];
        w_base  = r_mode ? xa_pkg::BASE_8BIT : xa_pkg::BASE_4BIT;
        n_unit.codes     = {i_codes_d, i_codes_c, i_codes_b, i_codes_a};
        n_unit.shift     = w_base - $signed({1'b0, w_range});
        n_unit.filt      = i_unit_header[5:4];
        n_unit.chan      = i_channel_sel;
        n_unit.eight_bit = r_mode;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_mode <= i_cfg_eight_bit_mode;
            end
            if (i_valid && o_ready) begin
                r_valid <= 1'b1;
            end else if (i_q_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_unit <= n_unit;
        end
    end

endmodule

`default_nettype wire

// ----- design/xa_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module xa_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_wr_valid,
    output logic               o_wr_ready,
    input  wire xa_pkg::t_unit i_wr_data,
    output logic               o_rd_valid,
    input  wire logic          i_rd_ready,
    output xa_pkg::t_unit      o_rd_data
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    xa_pkg::t_unit    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push;
    logic             w_pop;

    assign o_wr_ready = (r_count != CNT_W'(DEPTH));
    assign o_rd_valid = (r_count != '0);
    assign o_rd_data  = r_mem[r_rd_ptr];
    assign w_push     = i_wr_valid && o_wr_ready;
    assign w_pop      = o_rd_valid && i_rd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

`default_nettype wire

// ----- design/xa_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module xa_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_q_valid,
    output logic               o_q_ready,
    input  wire xa_pkg::t_unit i_q_data,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic signed [15:0] o_pcm_sample,
    output logic               o_sample_channel,
    output logic               o_last_of_unit
);

    localparam logic [xa_pkg::IDX_W-1:0] IDX_LAST =
        xa_pkg::IDX_W'(xa_pkg::SAMPLES_PER_UNIT - 1);

    logic                              r_busy;
    logic [xa_pkg::IDX_W-1:0]          r_idx;
    logic [xa_pkg::UNIT_CODES_W-1:0]   r_codes;
    logic signed [4:0]                 r_shift;
    logic signed [7:0]                 r_pc;
    logic signed [7:0]                 r_nc;
    logic                              r_chan;
    logic                              r_eight;
    logic signed [15:0]                r_recent [2];
    logic signed [15:0]                r_older  [2];
    logic                              r_out_valid;
    logic signed [15:0]                r_pcm;
    logic                              r_out_chan;
    logic                              r_out_last;

    logic               w_adv;
    logic               w_last;
    logic               w_load;
    logic [7:0]         w_byte;
    logic signed [7:0]  w_code;
    logic signed [19:0] w_code_x;
    logic signed [19:0] w_scaled;
    logic [3:0]         w_rsh;
    logic signed [23:0] w_prod_p;
    logic signed [23:0] w_prod_n;
    logic signed [24:0] w_acc;
    logic signed [18:0] w_pred;
    logic signed [20:0] w_sum;
    logic signed [15:0] w_val;

    assign w_adv     = r_busy && (!r_out_valid || i_ready);
    assign w_last    = (r_idx == IDX_LAST);
    assign o_q_ready = !r_busy || (w_adv && w_last);
    assign w_load    = o_q_ready && i_q_valid;

    assign o_valid          = r_out_valid;
    assign o_pcm_sample     = r_pcm;
    assign o_sample_channel = r_out_chan;
    assign o_last_of_unit   = r_out_last;

    always_comb begin
        w_byte   = r_codes[xa_pkg::CODE_BITS-1:0];
        w_code   = r_eight ? $signed(w_byte) : 8'(signed'(w_byte[3:0]));
        w_code_x = 20'(w_code);
        w_rsh    = 4'(-r_shift);
        if (r_shift >= 0) begin
            w_scaled = w_code_x <<< r_shift[3:0];
        end else begin
            w_scaled = w_code_x >>> w_rsh;
        end
        w_prod_p = r_recent[r_chan] * r_pc;
        w_prod_n = r_older[r_chan] * r_nc;
        w_acc    = 25'(w_prod_p) + 25'(w_prod_n) + 25'sd32;
        w_pred   = w_acc[24:6];
        w_sum    = 21'(w_scaled) + 21'(w_pred);
        if (w_sum > 21'sd32767) begin
            w_val = 16'sh7FFF;
        end else if (w_sum < -21'sd32768) begin
            w_val = 16'sh8000;
        end else begin
            w_val = w_sum[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
            r_recent[0] <= '0;
            r_recent[1] <= '0;
            r_older[0]  <= '0;
            r_older[1]  <= '0;
        end else begin
            if (w_load) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (w_adv) begin
                r_idx <= r_idx + 1'b1;
                if (w_last) begin
                    r_busy <= 1'b0;
                end
            end
            if (w_adv) begin
                r_out_valid      <= 1'b1;
                r_recent[r_chan] <= w_val;
                r_older[r_chan]  <= r_recent[r_chan];
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_codes <= i_q_data.codes;
            r_shift <= i_q_data.shift;
            r_pc    <= xa_pkg::pos_coef(i_q_data.filt);
            r_nc    <= xa_pkg::neg_coef(i_q_data.filt);
            r_chan  <= i_q_data.chan;
            r_eight <= i_q_data.eight_bit;
        end else if (w_adv) begin
            r_codes <= r_codes >> xa_pkg::CODE_BITS;
        end
        if (w_adv) begin
            r_pcm      <= w_val;
            r_out_chan <= r_chan;
            r_out_last <= w_last;
        end
    end

endmodule

`default_nettype wire

// ----- design/xa_adpcm_unit_decoder.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel  Handshake                Word
// in       i_valid / o_ready        header, 4 x 56-bit codes, channel
// out      o_valid / i_ready        one 16-bit sample, channel, last flag
// cfg      i_cfg_valid / o_cfg_ready  eight_bit_mode
//
// One sample per cycle while i_ready holds: each sample needs the previous one
// from the same channel's history, so the predictor loop sets the rate.
// First sample passes the front register, queue, unit registers and sample
// register. Front holds one unit and the queue QUEUE_DEPTH more.
// Synchronous reset clears history, mode, queue and valids. Output stalls
// freeze the sample loop; input stalls only once front and queue are full.

module xa_adpcm_unit_decoder #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic [7:0]           i_unit_header,
    input  wire logic [55:0]          i_codes_a,
    input  wire logic [55:0]          i_codes_b,
    input  wire logic [55:0]          i_codes_c,
    input  wire logic [55:0]          i_codes_d,
    input  wire logic                 i_channel_sel,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic signed [15:0]        o_pcm_sample,
    output logic                      o_sample_channel,
    output logic                      o_last_of_unit,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic                 i_cfg_eight_bit_mode
);

    logic          w_fq_valid;
    logic          w_fq_ready;
    xa_pkg::t_unit w_fq_data;
    logic          w_qb_valid;
    logic          w_qb_ready;
    xa_pkg::t_unit w_qb_data;

    xa_front u_front (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (i_valid),
        .o_ready              (o_ready),
        .i_unit_header        (i_unit_header),
        .i_codes_a            (i_codes_a),
        .i_codes_b            (i_codes_b),
        .i_codes_c            (i_codes_c),
        .i_codes_d            (i_codes_d),
        .i_channel_sel        (i_channel_sel),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_eight_bit_mode (i_cfg_eight_bit_mode),
        .o_q_valid            (w_fq_valid),
        .i_q_ready            (w_fq_ready),
        .o_q_data             (w_fq_data)
    );

    xa_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (w_fq_valid),
        .o_wr_ready (w_fq_ready),
        .i_wr_data  (w_fq_data),
        .o_rd_valid (w_qb_valid),
        .i_rd_ready (w_qb_ready),
        .o_rd_data  (w_qb_data)
    );

    xa_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_valid        (w_qb_valid),
        .o_q_ready        (w_qb_ready),
        .i_q_data         (w_qb_data),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_pcm_sample     (o_pcm_sample),
        .o_sample_channel (o_sample_channel),
        .o_last_of_unit   (o_last_of_unit)
    );

endmodule

`default_nettype wire

// ----- tb/xa_adpcm_unit_decoder_tb.sv -----
`timescale 1ns / 1ps

module xa_adpcm_unit_decoder_tb;

    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 6;
    localparam int IDLE_PCT       = 16;
    localparam int HOLD_CYCLES    = 300;
    localparam int STALL_LIMIT    = 4000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int UNIT_SAMPLES   = 28;
    localparam bit MODE_4BIT      = 1'b0;
    localparam bit MODE_8BIT      = 1'b1;

    typedef struct packed {
        logic [7:0]        header;
        logic [3:0][55:0]  codes;
        logic              chan;
    } t_unit_word;

    typedef struct {
        logic signed [15:0] pcm;
        logic               chan;
        logic               last;
    } t_sample_word;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic [7:0]         i_unit_header;
    logic [55:0]        i_codes_a;
    logic [55:0]        i_codes_b;
    logic [55:0]        i_codes_c;
    logic [55:0]        i_codes_d;
    logic               i_channel_sel;
    logic               o_valid;
    logic               i_ready;
    logic signed [15:0] o_pcm_sample;
    logic               o_sample_channel;
    logic               o_last_of_unit;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic               i_cfg_eight_bit_mode;

    // predictor state
    logic signed [15:0] hist_recent [2];
    logic signed [15:0] hist_older  [2];
    bit                 eight_bit;
    int                 tap_recent [4] = '{0, 60, 115, 98};
    int                 tap_older  [4] = '{0, 0, -52, -55};

    t_sample_word       pending_samples [$];
    int                 mismatch_count = 0;
    int                 quiet_cycles   = 0;
    bit                 quiet          = 1'b0;
    bit                 hold_pending   = 1'b0;

    xa_adpcm_unit_decoder DUT (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (i_valid),
        .o_ready              (o_ready),
        .i_unit_header        (i_unit_header),
        .i_codes_a            (i_codes_a),
        .i_codes_b            (i_codes_b),
        .i_codes_c            (i_codes_c),
        .i_codes_d            (i_codes_d),
        .i_channel_sel        (i_channel_sel),
        .o_valid              (o_valid),
        .i_ready              (i_ready),
        .o_pcm_sample         (o_pcm_sample),
        .o_sample_channel     (o_sample_channel),
        .o_last_of_unit       (o_last_of_unit),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_eight_bit_mode (i_cfg_eight_bit_mode)
    );

    initial i_clk = 1'b0;
    always #(CLK_HALF) i_clk = ~i_clk;

    function automatic logic [7:0] make_header(input logic [1:0] spare, input logic [1:0] filt,
                                               input logic [3:0] rng);
        return {spare, filt, rng};
    endfunction

    function automatic t_unit_word fill_unit(input logic [7:0] hdr, input logic [7:0] code_byte,
                                             input logic ch);
        t_unit_word u;
        u.header = hdr;
        u.codes  = {UNIT_SAMPLES{code_byte}};
        u.chan   = ch;
        return u;
    endfunction

    function automatic t_unit_word random_unit(input logic [7:0] hdr, input logic ch);
        t_unit_word u;
        u.header = hdr;
        for (int g = 0; g < 4; g++)
            u.codes[g] = 56'({$urandom, $urandom});
        u.chan = ch;
        return u;
    endfunction

    // decode one unit into the expected samples and advance the channel history
    task automatic predict_unit_samples(input t_unit_word u);
        int           rng;
        int           shift;
        int           code;
        int           scaled;
        int           pred;
        int           val;
        logic [7:0]   b;
        logic [1:0]   filt;
        logic [55:0]  grp;
        t_sample_word s;
        rng  = int'(u.header[3:0]);
        filt = u.header[5:4];
        if (rng > int'(xa_pkg::RANGE_MAX))
            rng = int'(xa_pkg::RANGE_SUBST);
        shift = int'(eight_bit ? xa_pkg::BASE_8BIT : xa_pkg::BASE_4BIT) - rng;
        for (int i = 0; i < UNIT_SAMPLES; i++) begin
            grp = u.codes[i / 7];
            b   = grp[8 * (i % 7) +: 8];
            if (eight_bit)
                code = int'($signed(b));
            else
                code = int'($signed(b[3:0]));
            if (shift >= 0)
                scaled = code <<< shift;
            else
                scaled = code >>> (-shift);
            pred = (hist_recent[u.chan] * tap_recent[filt]
                    + hist_older[u.chan] * tap_older[filt] + 32) >>> 6;
            val = scaled + pred;
            if (val > 32767)
                val = 32767;
            else if (val < -32768)
                val = -32768;
            hist_older[u.chan]  = hist_recent[u.chan];
            hist_recent[u.chan] = val[15:0];
            s.pcm  = val[15:0];
            s.chan = u.chan;
            s.last = (i == UNIT_SAMPLES - 1);
            pending_samples.insert(pending_samples.size(), s);
        end
    endtask

    task automatic send_unit(input t_unit_word u);
        while (!quiet && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_unit_header <= u.header;
        i_codes_a     <= u.codes[0];
        i_codes_b     <= u.codes[1];
        i_codes_c     <= u.codes[2];
        i_codes_d     <= u.codes[3];
        i_channel_sel <= u.chan;
        do @(posedge i_clk); while (!o_ready);
        predict_unit_samples(u);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_samples.size() != 0);
    endtask

    task automatic write_mode(input bit mode);
        i_cfg_valid          <= 1'b1;
        i_cfg_eight_bit_mode <= mode;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        eight_bit = mode;
    endtask

    task automatic test_directed_4bit();
        write_mode(MODE_4BIT);
        send_unit(fill_unit(make_header(2'd0, xa_pkg::FILT_NONE, 4'd0), 8'h77, 1'b0));
        send_unit(fill_unit(make_header(2'd0, xa_pkg::FILT_ONE, 4'd0), 8'h77, 1'b0));
        send_unit(fill_unit(make_header(2'd0, xa_pkg::FILT_NONE, 4'd0), 8'h88, 1'b1));
        send_unit(fill_unit(make_header(2'd0, xa_pkg::FILT_TWO, 4'd0), 8'h88, 1'b1));
        send_unit(fill_unit(make_header(2'd3, xa_pkg::FILT_THREE, 4'd12), 8'hF1, 1'b0));
        send_unit(fill_unit(make_header(2'd0, xa_pkg::FILT_TWO, 4'd13), 8'h0F, 1'b1));
        send_unit(fill_unit(make_header(2'd2, xa_pkg::FILT_THREE, 4'd15), 8'hA5, 1'b0));
        send_unit(fill_unit(make_header(2'd1, xa_pkg::FILT_ONE, 4'd14), 8'h5A, 1'b1));
        send_unit(fill_unit(make_header(2'd0, xa_pkg::FILT_NONE, 4'd6), 8'h00, 1'b0));
        send_unit(fill_unit(make_header(2'd3, xa_pkg::FILT_THREE, 4'd4), 8'hFF, 1'b1));
        send_unit(random_unit(8'hFF, 1'b0));
        send_unit(random_unit(8'h00, 1'b1));
        wait_drained();
    endtask

    task automatic test_directed_8bit();
        write_mode(MODE_8BIT);
        send_unit(fill_unit(make_header(2'd0, xa_pkg::FILT_NONE, 4'd0), 8'h7F, 1'b0));
        send_unit(fill_unit(make_header(2'd0, xa_pkg::FILT_ONE, 4'd0), 8'h7F, 1'b0));
        send_unit(fill_unit(make_header(2'd0, xa_pkg::FILT_NONE, 4'd0), 8'h80, 1'b1));
        send_unit(fill_unit(make_header(2'd0, xa_pkg::FILT_THREE, 4'd0), 8'h80, 1'b1));
        send_unit(fill_unit(make_header(2'd0, xa_pkg::FILT_NONE, 4'd12), 8'h81, 1'b0));
        send_unit(fill_unit(make_header(2'd3, xa_pkg::FILT_TWO, 4'd12), 8'h7F, 1'b1));
        send_unit(fill_unit(make_header(2'd2, xa_pkg::FILT_ONE, 4'd13), 8'hFF, 1'b0));
        send_unit(fill_unit(make_header(2'd1, xa_pkg::FILT_TWO, 4'd15), 8'h01, 1'b1));
        send_unit(fill_unit(make_header(2'd0, xa_pkg::FILT_THREE, 4'd8), 8'h00, 1'b0));
        send_unit(random_unit(make_header(2'd0, xa_pkg::FILT_TWO, 4'd11), 1'b1));
        wait_drained();
    endtask

    task automatic random_phase(input bit mode, input int count, input bit no_idle);
        write_mode(mode);
        quiet = no_idle;
        repeat (count)
            send_unit(random_unit(8'($urandom_range(255)), 1'($urandom_range(1))));
        wait_drained();
        quiet = 1'b0;
    endtask

    task automatic test_random_units();
        random_phase(MODE_4BIT, 36, 1'b0);
        random_phase(MODE_8BIT, 36, 1'b1);
        random_phase(MODE_4BIT, 36, 1'b0);
        random_phase(MODE_8BIT, 36, 1'b0);
    endtask

    // output held off while units keep coming, so the input side fills and stalls
    task automatic test_output_hold();
        hold_pending = 1'b1;
        repeat (8)
            send_unit(random_unit(8'($urandom_range(255)), 1'($urandom_range(1))));
        wait_drained();
    endtask

    task automatic test_sender_pause();
        repeat (3)
            send_unit(random_unit(8'($urandom_range(255)), 1'($urandom_range(1))));
        wait_drained();
        repeat (3)
            send_unit(random_unit(8'($urandom_range(255)), 1'($urandom_range(1))));
        wait_drained();
    endtask

    // sample receiver
    initial begin
        i_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_pending) begin
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_pending = 1'b0;
            end else begin
                i_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // sample checker
    always @(posedge i_clk) begin
        t_sample_word s;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_samples.size() == 0) begin
                $error("unexpected sample word: pcm_sample %0d", o_pcm_sample);
                mismatch_count++;
            end else begin
                s = pending_samples.pop_front();
                if (o_pcm_sample !== s.pcm) begin
                    $error("pcm_sample: expected %0d, got %0d", s.pcm, o_pcm_sample);
                    mismatch_count++;
                end
                if (o_sample_channel !== s.chan) begin
                    $error("sample_channel: expected %0d, got %0d", s.chan, o_sample_channel);
                    mismatch_count++;
                end
                if (o_last_of_unit !== s.last) begin
                    $error("last_of_unit: expected %0d, got %0d", s.last, o_last_of_unit);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog on cycles with no word moved on any channel
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        i_rst_n              = 1'b0;
        i_valid              = 1'b0;
        i_unit_header        = '0;
        i_codes_a            = '0;
        i_codes_b            = '0;
        i_codes_c            = '0;
        i_codes_d            = '0;
        i_channel_sel        = 1'b0;
        i_cfg_valid          = 1'b0;
        i_cfg_eight_bit_mode = 1'b0;
        eight_bit            = MODE_4BIT;
        for (int c = 0; c < 2; c++) begin
            hist_recent[c] = '0;
            hist_older[c]  = '0;
        end
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_4bit();
        test_directed_8bit();
        test_random_units();
        test_output_hold();
        test_sender_pause();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/xa_pkg.sv
design/xa_front.sv
design/xa_queue.sv
design/xa_back.sv
design/xa_adpcm_unit_decoder.sv
tb/xa_adpcm_unit_decoder_tb.sv
